@@ src/rtpd_pkg.sv @@
`default_nettype none
package rtpd_pkg;

  // width of the running pixel index; the frame limit is capped at 2**INDEX_W - 1
  localparam int INDEX_W = 16;
  localparam int CMP_W   = (INDEX_W > 16) ? INDEX_W : 16;

  localparam logic [7:0]  RUN_MARK       = 8'h20;
  localparam logic [7:0]  CHAR_BIAS      = 8'd33;
  localparam logic [15:0] FRAME_PIX_RST  = 16'd10000;

  typedef enum logic [7:0] {
    PH_C0     = 8'b0000_0001,
    PH_C1     = 8'b0000_0010,
    PH_C2     = 8'b0000_0100,
    PH_C3     = 8'b0000_1000,
    PH_MARK   = 8'b0001_0000,
    PH_CNT_HI = 8'b0010_0000,
    PH_CNT_LO = 8'b0100_0000,
    PH_PAD    = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       image_start;
    logic       stream_end;
  } in_t;

  typedef struct packed {
    logic [3:0]  red_level;
    logic [3:0]  green_level;
    logic [3:0]  blue_level;
    logic [15:0] start_index;
    logic [15:0] run_length;
    logic        frame_done;
  } out_t;

  typedef struct packed {
    phase_t               byte_phase;
    logic [23:0]          color_bits;
    logic [7:0]           count_high;
    logic [INDEX_W-1:0]   next_pixel;
    logic                 pixel_pending;
    logic                 frame_full;
  } state_t;

endpackage
`default_nettype wire

@@ src/rtpd_step.sv @@
`default_nettype none
module rtpd_step (
  input  var rtpd_pkg::state_t cur,
  input  var rtpd_pkg::in_t    item,
  input  wire logic [15:0]     frame_pixels,
  output rtpd_pkg::state_t     nxt,
  output logic                 emit,
  output rtpd_pkg::out_t       result
);
  import rtpd_pkg::*;

  localparam logic [CMP_W-1:0] IDX_CAP = CMP_W'((64'd1 << INDEX_W) - 64'd1);

  state_t           s;
  logic [5:0]       digit;
  logic             emit_req;
  logic [15:0]      emit_len;
  logic [23:0]      emit_color;
  logic [CMP_W-1:0] limit;
  logic [CMP_W-1:0] idx_ext;
  logic [CMP_W-1:0] remain;
  logic [CMP_W-1:0] len_ext;
  logic [CMP_W-1:0] run;
  logic [CMP_W-1:0] idx_new;

  assign digit = 6'(item.stream_byte - CHAR_BIAS);

  always_comb begin
    s = cur;
    if (item.image_start) begin
      s.byte_phase    = PH_C0;
      s.color_bits    = '0;
      s.count_high    = '0;
      s.next_pixel    = '0;
      s.pixel_pending = 1'b0;
      s.frame_full    = 1'b0;
    end

    emit_req   = 1'b0;
    emit_len   = 16'd0;
    emit_color = s.color_bits;

    case (s.byte_phase)
      PH_C0, PH_C1, PH_C2: begin
        s.color_bits = {s.color_bits[17:0], digit};
        s.byte_phase = (s.byte_phase == PH_C0) ? PH_C1 :
                       (s.byte_phase == PH_C1) ? PH_C2 : PH_C3;
      end
      PH_C3: begin
        s.color_bits    = {s.color_bits[17:0], digit};
        s.byte_phase    = PH_MARK;
        s.pixel_pending = 1'b1;
      end
      PH_MARK: begin
        if (item.stream_byte == RUN_MARK) begin
          s.byte_phase = PH_CNT_HI;
        end else begin
          // single pixel; this byte opens the next one
          emit_req        = 1'b1;
          emit_len        = 16'd1;
          s.pixel_pending = 1'b0;
          s.color_bits    = {18'd0, digit};
          s.byte_phase    = PH_C1;
        end
      end
      PH_CNT_HI: begin
        s.count_high = item.stream_byte;
        s.byte_phase = PH_CNT_LO;
      end
      PH_CNT_LO: begin
        emit_req        = 1'b1;
        emit_len        = {s.count_high, item.stream_byte};
        s.pixel_pending = 1'b0;
        s.byte_phase    = PH_PAD;
      end
      default: begin
        s.byte_phase = PH_C0;
      end
    endcase

    if (item.stream_end) begin
      if (s.pixel_pending) begin
        emit_req   = 1'b1;
        emit_len   = 16'd1;
        emit_color = s.color_bits;
      end
      s.pixel_pending = 1'b0;
      s.byte_phase    = PH_C0;
      s.count_high    = '0;
    end

    // clip against the frame limit
    limit   = (CMP_W'(frame_pixels) < IDX_CAP) ? CMP_W'(frame_pixels) : IDX_CAP;
    idx_ext = CMP_W'(s.next_pixel);
    remain  = limit - idx_ext;
    len_ext = CMP_W'(emit_len);
    run     = (len_ext < remain) ? len_ext : remain;
    idx_new = idx_ext + run;

    emit = emit_req && !s.frame_full && (emit_len != 16'd0) && (idx_ext < limit);

    result.red_level   = emit_color[23:20];
    result.green_level = emit_color[15:12];
    result.blue_level  = emit_color[7:4];
    result.start_index = 16'(s.next_pixel);
    result.run_length  = 16'(run);
    result.frame_done  = (idx_new == limit);

    if (emit) begin
      s.next_pixel = INDEX_W'(idx_new);
      s.frame_full = (idx_new == limit);
    end

    nxt = s;
  end
endmodule
`default_nettype wire

@@ src/rle_text_pixel_decoder_core.sv @@
`default_nettype none
// Run-length pixel stream decoder. Takes one compressed stream byte per cycle
// and returns at most one color run (4-bit RGB, first pixel index, clipped
// length, frame-full flag) per byte, in the cycle after the byte is taken.
// Decoder state updates from a short compare/add/min path, so bytes are
// accepted back to back; in_stall rises only while a finished run sits in
// the output register and out_stall holds it. frame_pixels may be written
// only while no byte is in flight.
module rle_text_pixel_decoder_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  var rtpd_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output rtpd_pkg::out_t      out_data,
  input  wire logic           cfg_wr_en,
  input  wire logic [15:0]    cfg_wr_data
);
  import rtpd_pkg::*;

  logic [15:0] frame_pixels;
  state_t      state;
  state_t      state_next;
  logic        emit;
  out_t        result;
  logic        accept;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  rtpd_step u_step (
    .cur          (state),
    .item         (in_data),
    .frame_pixels (frame_pixels),
    .nxt          (state_next),
    .emit         (emit),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pixels <= FRAME_PIX_RST;
    end else if (cfg_wr_en) begin
      frame_pixels <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.byte_phase    <= PH_C0;
      state.color_bits    <= '0;
      state.count_high    <= '0;
      state.next_pixel    <= '0;
      state.pixel_pending <= 1'b0;
      state.frame_full    <= 1'b0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_data <= result;
    end
  end
endmodule
`default_nettype wire

@@ verif/rle_text_pixel_decoder_core_tb.sv @@
`default_nettype none
module rle_text_pixel_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rtpd_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 20;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  rle_text_pixel_decoder_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #2 clk = ~clk;

  // decoder shadow state
  phase_t             dec_phase;
  logic [23:0]        dec_color;
  logic [7:0]         dec_count_hi;
  logic [INDEX_W-1:0] dec_index;
  logic               dec_pending;
  logic               dec_full;
  logic [15:0]        frame_size;

  out_t runs_due[$];
  int   errors = 0;
  int   bytes_sent = 0;
  int   cycle_count = 0;
  int   hold_left = 0;
  bit   steady = 1'b0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (errors < 40) $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic void clear_decoder();
    dec_phase    = PH_C0;
    dec_color    = '0;
    dec_count_hi = '0;
    dec_index    = '0;
    dec_pending  = 1'b0;
    dec_full     = 1'b0;
  endfunction

  // one color run into the frame, clipped at the usable limit
  function automatic bit place_run(input int unsigned len, output out_t run);
    int unsigned lim;
    int unsigned span;
    int unsigned cap;
    cap = (1 << INDEX_W) - 1;
    lim = (frame_size < cap) ? frame_size : cap;
    run = '0;
    if (dec_full || len == 0 || dec_index >= lim) return 1'b0;
    span = lim - dec_index;
    if (len < span) span = len;
    run.red_level   = dec_color[23:20];
    run.green_level = dec_color[15:12];
    run.blue_level  = dec_color[7:4];
    run.start_index = 16'(dec_index);
    run.run_length  = 16'(span);
    dec_index = INDEX_W'(dec_index + span);
    dec_full  = (dec_index == lim);
    run.frame_done = dec_full;
    return 1'b1;
  endfunction

  function automatic bit decode_byte(input in_t item, output out_t run);
    logic [7:0] diff;
    logic [5:0] digit;
    bit         hit;
    hit   = 1'b0;
    run   = '0;
    diff  = item.stream_byte - CHAR_BIAS;
    digit = diff[5:0];
    if (item.image_start) clear_decoder();
    case (dec_phase)
      PH_C0, PH_C1, PH_C2, PH_C3: begin
        dec_color = {dec_color[17:0], digit};
        case (dec_phase)
          PH_C0: dec_phase = PH_C1;
          PH_C1: dec_phase = PH_C2;
          PH_C2: dec_phase = PH_C3;
          default: begin
            dec_phase   = PH_MARK;
            dec_pending = 1'b1;
          end
        endcase
      end
      PH_MARK: begin
        if (item.stream_byte == RUN_MARK) begin
          dec_phase = PH_CNT_HI;
        end else begin
          hit = place_run(1, run);
          dec_pending = 1'b0;
          dec_color   = {18'd0, digit};
          dec_phase   = PH_C1;
        end
      end
      PH_CNT_HI: begin
        dec_count_hi = item.stream_byte;
        dec_phase    = PH_CNT_LO;
      end
      PH_CNT_LO: begin
        hit = place_run({dec_count_hi, item.stream_byte}, run);
        dec_pending = 1'b0;
        dec_phase   = PH_PAD;
      end
      default: dec_phase = PH_C0;
    endcase
    if (item.stream_end) begin
      // a held color goes out as a single pixel
      if (dec_pending) hit = place_run(1, run);
      dec_pending  = 1'b0;
      dec_phase    = PH_C0;
      dec_count_hi = '0;
    end
    return hit;
  endfunction

  // input capture and result check share one process so ordering is fixed
  always @(posedge clk) begin
    out_t pred;
    out_t got;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        if (decode_byte(in_data, pred)) runs_due.push_back(pred);
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (runs_due.size() == 0) begin
          report_mismatch("unexpected run, start_index", got.start_index, -1);
        end else begin
          pred = runs_due.pop_front();
          if (got.red_level !== pred.red_level)
            report_mismatch("red_level", got.red_level, pred.red_level);
          if (got.green_level !== pred.green_level)
            report_mismatch("green_level", got.green_level, pred.green_level);
          if (got.blue_level !== pred.blue_level)
            report_mismatch("blue_level", got.blue_level, pred.blue_level);
          if (got.start_index !== pred.start_index)
            report_mismatch("start_index", got.start_index, pred.start_index);
          if (got.run_length !== pred.run_length)
            report_mismatch("run_length", got.run_length, pred.run_length);
          if (got.frame_done !== pred.frame_done)
            report_mismatch("frame_done", got.frame_done, pred.frame_done);
        end
      end
    end
  end

  // receiver back-pressure: a random hold after each accepted run
  always @(posedge clk) begin
    int n;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) n = steady ? 0 : $urandom_range(0, 17);
      else n = hold_left;
      if (n > 0) begin
        out_stall <= 1'b1;
        hold_left <= n - 1;
      end else begin
        out_stall <= 1'b0;
        hold_left <= 0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rle_text_pixel_decoder_core_tb: FAIL");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic st, input logic en);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{stream_byte: b, image_start: st, stream_end: en};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    // let the checker log a byte taken at the previous edge
    @(posedge clk);
    while (runs_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (runs_due.size() != 0) begin
      report_mismatch("runs never returned", 0, runs_due.size());
      runs_due.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame_pixels(input logic [15:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    frame_size  = v;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(33, 96));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hFFFF;
    if (r == 2) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(1, 12));
  endfunction

  task automatic send_noise(input int n);
    for (int k = 0; k < n; k++)
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0,
                $urandom_range(0, 9) == 0);
  endtask

  task automatic send_pixel(input bit fresh);
    int          kind;
    logic [15:0] cnt;
    for (int k = 0; k < 4; k++)
      send_byte(pick_char(), fresh && k == 0, $urandom_range(0, 79) == 0);
    kind = $urandom_range(0, 11);
    cnt  = pick_count();
    if (kind < 6) begin
      send_byte(RUN_MARK, 1'b0, 1'b0);
      send_byte(cnt[15:8], 1'b0, 1'b0);
      send_byte(cnt[7:0], 1'b0, 1'b0);
      send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    end else if (kind == 6) begin
      send_byte(RUN_MARK, 1'b0, 1'b1);
    end else if (kind == 7) begin
      send_byte(RUN_MARK, 1'b0, 1'b0);
      send_byte(cnt[15:8], 1'b0, 1'b1);
    end
    // otherwise the next pixel's first character ends this one
  endtask

  task automatic random_images(input int n_bytes);
    int target;
    int pixels;
    int kind;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      steady = ($urandom_range(0, 4) == 0);
      pixels = $urandom_range(1, 12);
      for (int p = 0; p < pixels; p++) send_pixel(p == 0);
      kind = $urandom_range(0, 3);
      if (kind == 0) send_byte(pick_char(), 1'b0, 1'b1);
      else if (kind == 1) send_noise($urandom_range(1, 6));
    end
    steady = 1'b0;
  endtask

  task automatic test_default_frame();
    random_images(200);
  endtask

  task automatic test_directed();
    set_frame_pixels(16'd5);
    // black pixel with a zero count: nothing comes out
    send_byte(8'h21, 1'b1, 1'b0);
    send_byte(8'h21, 1'b0, 1'b0);
    send_byte(8'h21, 1'b0, 1'b0);
    send_byte(8'h21, 1'b0, 1'b0);
    send_byte(RUN_MARK, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    // top printable and non-printable characters, single pixel
    send_byte(8'h60, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'h7E, 1'b0, 1'b0);
    send_byte(8'h21, 1'b0, 1'b0);
    send_byte(8'h5F, 1'b0, 1'b0);
    send_byte(8'h40, 1'b0, 1'b0);
    // maximum count, clipped to fill the frame
    send_byte(RUN_MARK, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    // new image, stream end right after a full pixel
    send_byte(8'h30, 1'b1, 1'b0);
    send_byte(8'h31, 1'b0, 1'b0);
    send_byte(8'h32, 1'b0, 1'b0);
    send_byte(8'h33, 1'b0, 1'b1);
    // stream end while the count high byte is held
    send_byte(8'h34, 1'b0, 1'b0);
    send_byte(8'h35, 1'b0, 1'b0);
    send_byte(8'h36, 1'b0, 1'b0);
    send_byte(8'h37, 1'b0, 1'b0);
    send_byte(RUN_MARK, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    // partial pixel at stream end is dropped
    send_byte(8'h38, 1'b0, 1'b0);
    send_byte(8'h39, 1'b0, 1'b1);
  endtask

  task automatic test_single_pixel_frame();
    set_frame_pixels(16'd1);
    random_images(250);
  endtask

  task automatic test_max_frame();
    set_frame_pixels(16'hFFFF);
    random_images(350);
  endtask

  task automatic test_small_frames();
    repeat (4) begin
      set_frame_pixels(16'($urandom_range(2, 40)));
      random_images(150);
    end
  endtask

  task automatic test_noise();
    set_frame_pixels(16'($urandom_range(1, 300)));
    send_noise(200);
  endtask

  initial begin
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    rst         <= 1'b1;
    clear_decoder();
    frame_size = FRAME_PIX_RST;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_frame();
    test_directed();
    test_single_pixel_frame();
    test_max_frame();
    test_small_frames();
    test_noise();
    drain();

    if (errors == 0) begin
      $display("rle_text_pixel_decoder_core_tb: PASS");
    end else begin
      $display("rle_text_pixel_decoder_core_tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
